/* rtl/mwc_pkg.sv */
// Shared constants, codes and types for the masked wrap-around convolution core.
package mwc_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 512;
    localparam int MAX_KERNEL = 15;
    localparam int PIXEL_BITS = 16;

    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int KIDX_BITS = $clog2(MAX_KERNEL);
    localparam int PADDR_BITS = ROW_BITS + COL_BITS;
    localparam int KADDR_BITS = 2 * KIDX_BITS;
    localparam int COEF_BITS = 16;
    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);

    // Register widths as seen on the configuration port
    localparam int RROWS_BITS = 9;
    localparam int RCOLS_BITS = 10;
    localparam int RKSZ_BITS  = 4;
    // Effective value widths
    localparam int EROWS_BITS = ROW_BITS + 1;
    localparam int ECOLS_BITS = COL_BITS + 1;
    localparam int HALF_BITS  = KIDX_BITS - 1;

    localparam logic [RROWS_BITS-1:0] ROWS_RESET = RROWS_BITS'(240);
    localparam logic [RCOLS_BITS-1:0] COLS_RESET = RCOLS_BITS'(320);
    localparam logic [RKSZ_BITS-1:0]  KSZ_RESET  = RKSZ_BITS'(11);

    // Register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_KSZ  = 2'd2;

    // Operation codes
    localparam logic [1:0] OP_KLOAD   = 2'd0;
    localparam logic [1:0] OP_PLOAD   = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    // Effective geometry after clamping
    typedef struct packed {
        logic [EROWS_BITS-1:0] rows;
        logic [ECOLS_BITS-1:0] cols;
        logic [KIDX_BITS-1:0]  ksz;
        logic [HALF_BITS-1:0]  half;
    } cfg_t;

endpackage

/* rtl/mwc_regs.sv */
// Configuration registers with APB-style access and clamped geometry outputs.
module mwc_regs
    import mwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [RROWS_BITS-1:0] rows_reg;
    logic [RCOLS_BITS-1:0] cols_reg;
    logic [RKSZ_BITS-1:0]  ksz_reg;
    logic                  wr_en;
    logic [RKSZ_BITS-1:0]  k_clamp;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            ksz_reg  <= KSZ_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ROWS: rows_reg <= pwdata[RROWS_BITS-1:0];
                REG_COLS: cols_reg <= pwdata[RCOLS_BITS-1:0];
                REG_KSZ:  ksz_reg  <= pwdata[RKSZ_BITS-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            REG_KSZ:  prdata = 32'(ksz_reg);
            default:  prdata = '0;
        endcase
    end

    // Clamp geometry: zero acts as one, too large acts as the maximum,
    // an even kernel side drops to the next lower odd one.
    always_comb
    begin
        if (rows_reg == '0)
            cfg.rows = EROWS_BITS'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            cfg.rows = EROWS_BITS'(MAX_ROWS);
        else
            cfg.rows = EROWS_BITS'(rows_reg);

        if (cols_reg == '0)
            cfg.cols = ECOLS_BITS'(1);
        else if (int'(cols_reg) > MAX_COLS)
            cfg.cols = ECOLS_BITS'(MAX_COLS);
        else
            cfg.cols = ECOLS_BITS'(cols_reg);

        if (ksz_reg == '0)
            k_clamp = RKSZ_BITS'(1);
        else if (int'(ksz_reg) > MAX_KERNEL)
            k_clamp = RKSZ_BITS'(MAX_KERNEL);
        else
            k_clamp = ksz_reg;
        if (k_clamp[0] == 1'b0)
            k_clamp = k_clamp - RKSZ_BITS'(1);
        if (k_clamp == '0)
            k_clamp = RKSZ_BITS'(1);

        cfg.ksz  = KIDX_BITS'(k_clamp);
        cfg.half = cfg.ksz[KIDX_BITS-1:1];
    end

endmodule

/* rtl/mwc_pixel_mem.sv */
// Pixel store: value plus mask bit per entry, one write and one registered read port.
module mwc_pixel_mem
    import mwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [PADDR_BITS-1:0] waddr,
    input  logic [PIXEL_BITS:0]   wdata,
    input  logic [PADDR_BITS-1:0] raddr,
    output logic [PIXEL_BITS:0]   rdata
);

    logic [PIXEL_BITS:0] mem [MAX_ROWS*MAX_COLS];
    logic [PIXEL_BITS:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mwc_kernel_mem.sv */
// Kernel coefficient store addressed by row and column, registered read.
module mwc_kernel_mem
    import mwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [KADDR_BITS-1:0] waddr,
    input  logic [COEF_BITS-1:0]  wdata,
    input  logic [KADDR_BITS-1:0] raddr,
    output logic [COEF_BITS-1:0]  rdata
);

    logic [COEF_BITS-1:0] mem [2**KADDR_BITS];
    logic [COEF_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mwc_mac.sv */
// Shared multiply-accumulate unit: registered product, then accumulate.
module mwc_mac
    import mwc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  in_valid,
    input  logic [PIXEL_BITS-1:0] pix,
    input  logic [COEF_BITS-1:0]  coef,
    output logic                  busy,
    output logic [ACC_BITS-1:0]   acc
);

    logic [PROD_BITS-1:0] prod_reg;
    logic                 pvalid_reg;
    logic [ACC_BITS-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= 1'b0;
        else
            pvalid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(pix) * PROD_BITS'(coef);
        if (clear)
            acc_reg <= '0;
        else if (pvalid_reg)
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
    end

    assign busy = pvalid_reg;
    assign acc  = acc_reg;

endmodule

/* rtl/masked_wraparound_convolution_2d_core.sv */
// Top level: request sequencer for loads and masked wrap-around convolution.
// A load completes at its accept edge. A masked compute raises m_tvalid after the center
// read and check, the step to the first tap, k*k taps (k = effective kernel side) fed
// to the single shared MAC at one product per cycle, and the drain. Pass-through and
// out-of-image computes skip the step, taps and drain. One request at a time.
// Reset (rst_n, async low) clears control state and loads the register reset values.
module masked_wraparound_convolution_2d_core
    import mwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[7:0], col[16:8], value[32:17], mask_bit[33], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result[15:0]
    output logic [0:0]  m_tuser,   // saturated[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER_RD,
        ST_CENTER_CHK,
        ST_ADJ,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Request fields
    logic [ROW_BITS-1:0]   in_row;
    logic [COL_BITS-1:0]   in_col;
    logic [PIXEL_BITS-1:0] in_value;
    logic                  in_mask;
    logic [1:0]            in_op;
    logic                  accept;

    assign in_row   = s_tdata[7:0];
    assign in_col   = s_tdata[16:8];
    assign in_value = s_tdata[32:17];
    assign in_mask  = s_tdata[33];
    assign in_op    = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    cfg_t cfg;

    mwc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer registers
    logic [ROW_BITS-1:0]   row_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [ROW_BITS-1:0]   i_reg;         // wrapped image row of current tap
    logic [COL_BITS-1:0]   j_reg;         // wrapped image column of current tap
    logic [COL_BITS-1:0]   j_start_reg;   // column of the first tap in a kernel row
    logic [KIDX_BITS-1:0]  r1_reg;
    logic [KIDX_BITS-1:0]  c1_reg;
    logic [HALF_BITS-1:0]  adj_cnt_reg;
    logic                  rd_valid_reg;
    logic                  use_acc_reg;
    logic [PIXEL_BITS-1:0] pend_res_reg;
    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    // Memories
    logic                  pix_we;
    logic [PADDR_BITS-1:0] pix_raddr;
    logic [PIXEL_BITS:0]   pix_rdata;
    logic                  ker_we;
    logic [COEF_BITS-1:0]  ker_rdata;

    // Pixel loads always land inside the store; kernel loads must fit the kernel.
    assign pix_we = accept && (in_op == OP_PLOAD)
                    && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
    assign ker_we = accept && (in_op == OP_KLOAD)
                    && (int'(in_row) < MAX_KERNEL) && (int'(in_col) < MAX_KERNEL);
    assign pix_raddr = (state_reg == ST_RUN) ? {i_reg, j_reg} : {row_reg, col_reg};

    mwc_pixel_mem u_pixel_mem (
        .clk   (clk),
        .we    (pix_we),
        .waddr ({in_row, in_col}),
        .wdata ({in_mask, in_value & PIX_MAX}),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    mwc_kernel_mem u_kernel_mem (
        .clk   (clk),
        .we    (ker_we),
        .waddr ({in_row[KIDX_BITS-1:0], in_col[KIDX_BITS-1:0]}),
        .wdata (in_value),
        .raddr ({r1_reg, c1_reg}),
        .rdata (ker_rdata)
    );

    // MAC: clear at the center check of every compute, feed one tap per cycle.
    logic                mac_clear;
    logic                mac_busy;
    logic [ACC_BITS-1:0] acc;

    assign mac_clear = (state_reg == ST_CENTER_CHK);

    mwc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (mac_clear),
        .in_valid (rd_valid_reg),
        .pix      (pix_rdata[PIXEL_BITS-1:0]),
        .coef     (ker_rdata),
        .busy     (mac_busy),
        .acc      (acc)
    );

    // Wrap helpers on the current tap position
    logic                  in_image;
    logic                  last_col;
    logic                  last_row;
    logic [ROW_BITS-1:0]   i_inc;
    logic [COL_BITS-1:0]   j_inc;
    logic [ROW_BITS-1:0]   i_dec;
    logic [COL_BITS-1:0]   j_dec;
    logic [ACC_BITS-PROD_BITS+PIXEL_BITS-1:0] sum;
    logic                  sum_sat;
    logic [PIXEL_BITS-1:0] fin_res;
    logic                  fin_sat;

    always_comb
    begin
        in_image = ({1'b0, row_reg} < cfg.rows) && ({1'b0, col_reg} < cfg.cols);
        last_col = (c1_reg == cfg.ksz - KIDX_BITS'(1));
        last_row = (r1_reg == cfg.ksz - KIDX_BITS'(1));
        i_inc = ({1'b0, i_reg} + EROWS_BITS'(1) == cfg.rows) ? '0 : i_reg + ROW_BITS'(1);
        j_inc = ({1'b0, j_reg} + ECOLS_BITS'(1) == cfg.cols) ? '0 : j_reg + COL_BITS'(1);
        i_dec = (i_reg == '0) ? ROW_BITS'(cfg.rows - EROWS_BITS'(1)) : i_reg - ROW_BITS'(1);
        j_dec = (j_reg == '0) ? COL_BITS'(cfg.cols - ECOLS_BITS'(1)) : j_reg - COL_BITS'(1);

        // Truncate the Q24.16 sum to Q24.0 and clamp to the pixel range
        sum     = acc[ACC_BITS-1:COEF_BITS];
        sum_sat = (sum > (ACC_BITS-COEF_BITS)'(PIX_MAX));
        if (use_acc_reg)
        begin
            fin_res = sum_sat ? PIX_MAX : sum[PIXEL_BITS-1:0];
            fin_sat = sum_sat;
        end
        else
        begin
            fin_res = pend_res_reg;
            fin_sat = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            use_acc_reg  <= 1'b0;
            adj_cnt_reg  <= '0;
            r1_reg       <= '0;
            c1_reg       <= '0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_RUN);
            // Drop a taken result; the finish state owns the flag while it runs.
            if (m_tready && (state_reg != ST_FINISH))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    // Loads complete in the accept cycle; only a compute advances.
                    if (accept && (in_op == OP_COMPUTE))
                    begin
                        row_reg   <= in_row;
                        col_reg   <= in_col;
                        state_reg <= ST_CENTER_RD;
                    end
                end
                ST_CENTER_RD:
                begin
                    state_reg <= ST_CENTER_CHK;
                end
                ST_CENTER_CHK:
                begin
                    if (!in_image)
                    begin
                        use_acc_reg  <= 1'b0;
                        pend_res_reg <= '0;
                        state_reg    <= ST_FINISH;
                    end
                    else if (!pix_rdata[PIXEL_BITS])
                    begin
                        use_acc_reg  <= 1'b0;
                        pend_res_reg <= pix_rdata[PIXEL_BITS-1:0];
                        state_reg    <= ST_FINISH;
                    end
                    else
                    begin
                        use_acc_reg <= 1'b1;
                        i_reg       <= row_reg;
                        j_reg       <= col_reg;
                        adj_cnt_reg <= cfg.half;
                        r1_reg      <= '0;
                        c1_reg      <= '0;
                        state_reg   <= ST_ADJ;
                    end
                end
                ST_ADJ:
                begin
                    // Step to the first tap: center plus half in both axes.
                    if (adj_cnt_reg == '0)
                    begin
                        j_start_reg <= j_reg;
                        state_reg   <= ST_RUN;
                    end
                    else
                    begin
                        i_reg       <= i_inc;
                        j_reg       <= j_inc;
                        adj_cnt_reg <= adj_cnt_reg - HALF_BITS'(1);
                    end
                end
                ST_RUN:
                begin
                    // Issue one tap per cycle; columns move left, rows move up.
                    if (last_col)
                    begin
                        c1_reg <= '0;
                        j_reg  <= j_start_reg;
                        i_reg  <= i_dec;
                        r1_reg <= r1_reg + KIDX_BITS'(1);
                        if (last_row)
                            state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        c1_reg <= c1_reg + KIDX_BITS'(1);
                        j_reg  <= j_dec;
                    end
                end
                ST_DRAIN:
                begin
                    // Hold until the last product is in the accumulator.
                    if (!rd_valid_reg && !mac_busy)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // Hold while an earlier result is still waiting downstream.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= fin_res;
                        m_tuser_reg  <= fin_sat;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
